// File: src/bfu_pkg.sv
// ----------------------------------------------------------------------------
// bfu_pkg: shared types and constants of the bit field unpacker
// Configuration register indexes, the configuration bundle that both the
// front and the back part use, and the queue sizing.
// ----------------------------------------------------------------------------
package bfu_pkg;

    // configuration channel
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_COUNT = 1'd1;

    // register fields and reset values
    localparam int CFG_WIDTH_W = 5;
    localparam int CFG_COUNT_W = 16;
    localparam logic [CFG_WIDTH_W-1:0] FIELD_WIDTH_RST = 5'd8;
    localparam logic [CFG_COUNT_W-1:0] FIELD_COUNT_RST = 16'd0;

    // item widths
    localparam int BYTE_W  = 8;
    localparam int FIELD_W = 16;

    // at most this many results come from one byte
    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

    // byte queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CFG_WIDTH_W-1:0] field_width;
        logic [CFG_COUNT_W-1:0] field_count;
    } cfg_t;

endpackage

// File: src/bit_field_unpacker.sv
// ----------------------------------------------------------------------------
// bit_field_unpacker: LSB-first fixed-width bit field unpacker
// Takes packed bytes and gives unsigned fields of the configured width,
// marking the last field of each block and the last field of each byte.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_       | in        | tdata[7:0] packed_byte
//  m_       | out       | tdata[15:0] field_value, tlast block_end,
//           |           | tuser run_end
//  cfg_     | in        | index 0 field_width, 1 field_count; data[15:0]
//
//  A byte gives 0 to 8 fields, one field per cycle unless the output stalls;
//  the single field-extract shifter in the back part sets this pace.
//  A byte passes the queue, bit buffer and output register to its first field.
//  Reset: synchronous, active low; width 8, count 0, buffer empty.
//  A stalled output holds fields in the output register; the two-entry byte
//  queue keeps the input side taking bytes meanwhile until it fills.
//
module bit_field_unpacker #(
    parameter int MAX_FIELD_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bfu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfu_pkg::CFG_DATA_W-1:0] cfg_data,
    // byte input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] packed_byte
    // field output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [15:0] field_value
    output logic                           m_tlast,   // block_end
    output logic                           m_tuser    // [0] run_end
);
    import bfu_pkg::*;

    cfg_t              cfg;
    logic              q_push;
    logic [BYTE_W-1:0] q_in_data;
    logic              q_ready;
    logic              q_pop;
    logic              q_valid;
    logic [BYTE_W-1:0] q_out_data;

    bfu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_push    (q_push),
        .q_data    (q_in_data),
        .q_ready   (q_ready)
    );

    bfu_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in_data),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out_data)
    );

    bfu_back #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_data   (q_out_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: src/bfu_front.sv
// ----------------------------------------------------------------------------
// bfu_front: configuration registers and input classification
// Holds the configuration, accepts bytes and forwards those that belong to
// a block; bytes taken while the field count is zero are dropped.
// ----------------------------------------------------------------------------
module bfu_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bfu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfu_pkg::CFG_DATA_W-1:0] cfg_data,
    output bfu_pkg::cfg_t                  cfg,
    // byte input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bfu_pkg::BYTE_W-1:0]     s_tdata,
    // to queue
    output logic                           q_push,
    output logic [bfu_pkg::BYTE_W-1:0]     q_data,
    input  logic                           q_ready
);
    import bfu_pkg::*;

    cfg_t cfg_reg;

    // configuration registers, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.field_width <= FIELD_WIDTH_RST;
            cfg_reg.field_count <= FIELD_COUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FIELD_WIDTH: cfg_reg.field_width <= cfg_data[CFG_WIDTH_W-1:0];
                REG_FIELD_COUNT: cfg_reg.field_count <= cfg_data[CFG_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    // accept while the queue has room; zero count drops the item
    assign s_tready = q_ready;
    assign q_push   = s_tvalid && s_tready && (cfg_reg.field_count != '0);
    assign q_data   = s_tdata;

endmodule

// File: src/bfu_queue.sv
// ----------------------------------------------------------------------------
// bfu_queue: short byte queue
// Two-entry FIFO that lets the front part and the back part stall apart.
// ----------------------------------------------------------------------------
module bfu_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [bfu_pkg::BYTE_W-1:0] push_data,
    output logic                       ready,
    input  logic                       pop,
    output logic                       valid,
    output logic [bfu_pkg::BYTE_W-1:0] pop_data
);
    import bfu_pkg::*;

    logic [BYTE_W-1:0]      data_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign ready    = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = data_reg[rd_ptr_reg];
    assign do_push  = push && ready;
    assign do_pop   = pop && valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/bfu_back.sv
// ----------------------------------------------------------------------------
// bfu_back: bit buffer and field extraction
// Appends queued bytes above the held bits and, unless the output stalls, sends
// one field per cycle via an output register, tags block and per-byte run ends.
// ----------------------------------------------------------------------------
module bfu_back #(
    parameter int MAX_FIELD_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bfu_pkg::cfg_t               cfg,
    // from queue
    input  logic                        q_valid,
    input  logic [bfu_pkg::BYTE_W-1:0]  q_data,
    output logic                        q_pop,
    // result output
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bfu_pkg::FIELD_W-1:0] m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);
    import bfu_pkg::*;

    localparam int BUF_W = MAX_FIELD_WIDTH + BYTE_W - 1;
    localparam int HW    = $clog2(BUF_W + 1);
    localparam int WW    = $clog2(MAX_FIELD_WIDTH + 1);

    logic [BUF_W-1:0]       buf_reg,  buf_next;
    logic [HW-1:0]          held_reg, held_next;
    logic [CFG_COUNT_W-1:0] done_reg, done_next;
    logic [RES_CNT_W-1:0]   n_reg,    n_next;
    logic                   act_reg,  act_next;

    logic                   out_valid_reg;
    logic [FIELD_W-1:0]     out_data_reg;
    logic                   out_last_reg;
    logic                   out_run_reg;

    logic [WW-1:0]          w;
    logic [HW-1:0]          w_h;
    logic [BUF_W-1:0]       mask;
    logic [BUF_W+FIELD_W-1:0] field_ext;
    logic                   out_free;
    logic                   emit;
    logic                   last;
    logic                   run_end;
    logic [BUF_W-1:0]       buf_a;
    logic [HW-1:0]          held_a;
    logic [HW-1:0]          held_b;

    // effective width: zero reads as one, clamp to the maximum
    always_comb begin
        if (cfg.field_width == '0) begin
            w = WW'(1);
        end else if (int'(cfg.field_width) > MAX_FIELD_WIDTH) begin
            w = WW'(MAX_FIELD_WIDTH);
        end else begin
            w = WW'(cfg.field_width);
        end
    end

    assign w_h  = HW'(w);
    assign mask = ~({BUF_W{1'b1}} << w);
    assign field_ext = {{FIELD_W{1'b0}}, buf_reg & mask};

    // one field leaves when the output register can take it
    assign out_free = !out_valid_reg || m_tready;
    assign emit     = act_reg && out_free;
    assign last     = ({1'b0, done_reg} + 1'b1) >= {1'b0, cfg.field_count};

    // state after the field leaves
    always_comb begin
        buf_a  = buf_reg;
        held_a = held_reg;
        if (emit) begin
            if (last) begin
                buf_a  = '0;
                held_a = '0;
            end else begin
                buf_a  = buf_reg >> w;
                held_a = held_reg - w_h;
            end
        end
    end

    assign run_end = last || (held_a < w_h) || (n_reg == RES_CNT_W'(MAX_RESULTS - 1));

    // next byte enters once the current one has given all its fields
    assign q_pop  = q_valid && (!act_reg || (emit && run_end));
    assign held_b = held_a + HW'(BYTE_W);

    always_comb begin
        buf_next  = buf_a;
        held_next = held_a;
        done_next = done_reg;
        n_next    = n_reg;
        act_next  = act_reg;
        if (emit) begin
            done_next = last ? '0 : done_reg + 1'b1;
            n_next    = n_reg + 1'b1;
            if (run_end) begin
                act_next = 1'b0;
            end
        end
        if (q_pop) begin
            buf_next  = buf_a | (BUF_W'(q_data) << held_a);
            held_next = held_b;
            n_next    = '0;
            act_next  = (held_b >= w_h);
        end
    end

    // bit buffer and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg  <= '0;
            held_reg <= '0;
            done_reg <= '0;
            n_reg    <= '0;
            act_reg  <= 1'b0;
        end else begin
            buf_reg  <= buf_next;
            held_reg <= held_next;
            done_reg <= done_next;
            n_reg    <= n_next;
            act_reg  <= act_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_data_reg <= field_ext[FIELD_W-1:0];
            out_last_reg <= last;
            out_run_reg  <= run_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_run_reg;

endmodule
